// File: design/dit_pkg.sv
// ---------------------------------------------------------------------------
// Disjoint interval tracker package
// Sizes, result status codes and sequencer states shared by the tracker.
// ---------------------------------------------------------------------------
package dit_pkg;

   // Table capacity and value width.
   localparam int MAX_RANGES = 16;
   localparam int VAL_BITS   = 16;

   // Table index and count widths follow from the capacity.
   localparam int IDX_BITS = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_BITS = $clog2(MAX_RANGES + 1);

   localparam logic [VAL_BITS-1:0] VAL_TOP = {VAL_BITS{1'b1}};

   // Request function codes.
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_LIST = 1'b1;

   typedef logic [VAL_BITS-1:0] value_type;
   typedef logic [CNT_BITS-1:0] count_type;
   typedef logic [IDX_BITS-1:0] index_type;

   typedef enum logic [2:0] {
      ST_NEW      = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_EXTENDED = 3'd2,
      ST_MERGED   = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_LIST,
      S_OUTPUT
   } state_type;

endpackage

// File: design/disjoint_interval_tracker_core.sv
// ---------------------------------------------------------------------------
// Disjoint interval tracker core
// Sorted table of disjoint, non-adjacent value ranges with add and list
// requests, run by a small sequencer over a single table access port.
// ---------------------------------------------------------------------------
// The block holds up to MAX_RANGES ranges in ascending order and takes one
// request at a time; req_ready is high only while it is idle. An add request
// first scans the table from the bottom, one entry a cycle, until it reaches
// the first range whose end is not below the value. Inserting a new range
// then moves every higher entry up by one place, one entry a cycle, and
// merging two ranges moves every higher entry down by one place in the same
// way. The scan and the shift that follows it together pass over each entry
// once, except that an insert passes twice over the entry at which its scan
// stops; the add then offers its single status result. A
// list request delivers one result per stored range, one a cycle while the
// consumer keeps rsp_ready high, and a single result marked invalid when the
// table is empty. The cost in every case is set by the table having one read
// and one write port, which the scan and the shifts share. The table contents
// are not cleared at reset; only the range count is, and no entry at or above
// the count is ever read.
module disjoint_interval_tracker_core
   import dit_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [VAL_BITS-1:0] req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_is_entry,
   output logic [2:0]          rsp_status,
   output logic [VAL_BITS-1:0] rsp_range_start,
   output logic [VAL_BITS-1:0] rsp_range_end,
   output logic                rsp_entry_valid,
   output logic                rsp_last
);

   // Range table: starts and ends, written at one address per cycle.
   value_type starts_ff [MAX_RANGES];
   value_type ends_ff   [MAX_RANGES];

   // Sequencer and datapath registers.
   state_type  state_ff,     state_in;
   count_type  count_ff,     count_in;
   count_type  idx_ff,       idx_in;
   count_type  pos_ff,       pos_in;
   value_type  value_ff,     value_in;
   value_type  prev_end_ff,  prev_end_in;

   // Result registers.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       is_entry_ff,  is_entry_in;
   status_type status_ff,    status_in;
   value_type  start_ff,     start_in;
   value_type  end_ff,       end_in;
   logic       ent_valid_ff, ent_valid_in;
   logic       last_ff,      last_in;

   // Table port.
   count_type  rd_ptr;
   index_type  rd_addr;
   value_type  rd_start;
   value_type  rd_end;
   logic       wr_start_en;
   logic       wr_end_en;
   count_type  wr_ptr;
   index_type  wr_addr;
   value_type  wr_start;
   value_type  wr_end;

   // Decision terms evaluated when the scan stops.
   logic       in_table;
   logic       scan_more;
   logic       hit;
   logic       has_left;
   logic       has_right;
   logic       full;
   logic       req_fire;
   logic       rsp_fire;
   logic       list_load;
   logic       list_last;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid_ff && rsp_ready;

   // The shift-up pass reads the entry below the one it writes; every other
   // access reads at the running index.
   always_comb begin
      case (state_ff)
         S_SHIFT_UP: rd_ptr = idx_ff - CNT_BITS'(1);
         default:    rd_ptr = idx_ff;
      endcase
   end

   assign rd_addr  = rd_ptr[IDX_BITS-1:0];
   assign rd_start = starts_ff[rd_addr];
   assign rd_end   = ends_ff[rd_addr];
   assign wr_addr  = wr_ptr[IDX_BITS-1:0];

   // The scan walks past every range that ends below the value. Where it
   // stops, the previous range (if any) is the only candidate left neighbour
   // and the current one the only candidate right neighbour or container.
   assign in_table  = idx_ff < count_ff;
   assign scan_more = in_table && (rd_end < value_ff);
   assign hit       = in_table && (rd_start <= value_ff);
   assign has_left  = (idx_ff != '0) && (value_ff != '0)
                      && (prev_end_ff == value_ff - VAL_BITS'(1));
   assign has_right = in_table && (value_ff != VAL_TOP)
                      && (rd_start == value_ff + VAL_BITS'(1));
   assign full      = count_ff == CNT_BITS'(MAX_RANGES);

   // A list entry is loaded whenever the result register is free or being
   // emptied in this cycle.
   assign list_load = (state_ff == S_LIST) && (!rsp_valid_ff || rsp_ready);
   assign list_last = (idx_ff + CNT_BITS'(1)) == count_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_func == FUNC_ADD) begin
                  state_in = S_SCAN;
               end else if (count_ff == '0) begin
                  state_in = S_OUTPUT;
               end else begin
                  state_in = S_LIST;
               end
            end
         end
         S_SCAN: begin
            if (!scan_more) begin
               if (hit || has_left || has_right) begin
                  state_in = (has_left && has_right) ? S_SHIFT_DOWN : S_OUTPUT;
               end else if (full) begin
                  state_in = S_OUTPUT;
               end else begin
                  state_in = S_SHIFT_UP;
               end
            end
         end
         S_SHIFT_UP: begin
            if (idx_ff == pos_ff) begin
               state_in = S_OUTPUT;
            end
         end
         S_SHIFT_DOWN: begin
            if (idx_ff == count_ff) begin
               state_in = S_OUTPUT;
            end
         end
         S_LIST: begin
            if (list_load && list_last) begin
               state_in = S_OUTPUT;
            end
         end
         S_OUTPUT: begin
            if (rsp_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath controls and register next values.
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      prev_end_in  = prev_end_ff;
      rsp_valid_in = rsp_valid_ff;
      is_entry_in  = is_entry_ff;
      status_in    = status_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      ent_valid_in = ent_valid_ff;
      last_in      = last_ff;
      wr_start_en  = 1'b0;
      wr_end_en    = 1'b0;
      wr_ptr       = idx_ff;
      wr_start     = rd_start;
      wr_end       = rd_end;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               value_in     = req_value;
               idx_in       = '0;
               is_entry_in  = req_func;
               status_in    = ST_NEW;
               start_in     = '0;
               end_in       = '0;
               ent_valid_in = 1'b0;
               last_in      = 1'b1;
               if (req_func == FUNC_LIST && count_ff == '0) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (scan_more) begin
               prev_end_in = rd_end;
               idx_in      = idx_ff + CNT_BITS'(1);
            end else if (hit) begin
               status_in    = ST_PRESENT;
               rsp_valid_in = 1'b1;
            end else if (has_left && has_right) begin
               // Left range takes the right range's end; the entries above
               // then close the gap.
               status_in = ST_MERGED;
               wr_end_en = 1'b1;
               wr_ptr    = idx_ff - CNT_BITS'(1);
               wr_end    = rd_end;
               idx_in    = idx_ff + CNT_BITS'(1);
            end else if (has_left) begin
               status_in    = ST_EXTENDED;
               wr_end_en    = 1'b1;
               wr_ptr       = idx_ff - CNT_BITS'(1);
               wr_end       = value_ff;
               rsp_valid_in = 1'b1;
            end else if (has_right) begin
               status_in    = ST_EXTENDED;
               wr_start_en  = 1'b1;
               wr_start     = value_ff;
               rsp_valid_in = 1'b1;
            end else if (full) begin
               status_in    = ST_FULL;
               rsp_valid_in = 1'b1;
            end else begin
               status_in = ST_NEW;
               pos_in    = idx_ff;
               idx_in    = count_ff;
            end
         end
         S_SHIFT_UP: begin
            wr_start_en = 1'b1;
            wr_end_en   = 1'b1;
            if (idx_ff == pos_ff) begin
               wr_start     = value_ff;
               wr_end       = value_ff;
               count_in     = count_ff + CNT_BITS'(1);
               rsp_valid_in = 1'b1;
            end else begin
               idx_in = idx_ff - CNT_BITS'(1);
            end
         end
         S_SHIFT_DOWN: begin
            if (idx_ff == count_ff) begin
               count_in     = count_ff - CNT_BITS'(1);
               rsp_valid_in = 1'b1;
            end else begin
               wr_start_en = 1'b1;
               wr_end_en   = 1'b1;
               wr_ptr      = idx_ff - CNT_BITS'(1);
               idx_in      = idx_ff + CNT_BITS'(1);
            end
         end
         S_LIST: begin
            if (list_load) begin
               rsp_valid_in = 1'b1;
               start_in     = rd_start;
               end_in       = rd_end;
               ent_valid_in = 1'b1;
               last_in      = list_last;
               idx_in       = idx_ff + CNT_BITS'(1);
            end
         end
         S_OUTPUT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      value_ff     <= value_in;
      prev_end_ff  <= prev_end_in;
      is_entry_ff  <= is_entry_in;
      status_ff    <= status_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      ent_valid_ff <= ent_valid_in;
      last_ff      <= last_in;
   end

   // Range table.
   always_ff @(posedge clock) begin
      if (wr_start_en) begin
         starts_ff[wr_addr] <= wr_start;
      end
      if (wr_end_en) begin
         ends_ff[wr_addr] <= wr_end;
      end
   end

   assign req_ready       = state_ff == S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_entry    = is_entry_ff;
   assign rsp_status      = status_ff;
   assign rsp_range_start = start_ff;
   assign rsp_range_end   = end_ff;
   assign rsp_entry_valid = ent_valid_ff;
   assign rsp_last        = last_ff;

endmodule

// File: tb/tb_disjoint_interval_tracker_core.sv
// ---------------------------------------------------------------------------
// Disjoint interval tracker core testbench
// Drives add and list requests through the valid/ready request channel and
// checks every response against a sorted-table predictor kept in step with
// the accepted requests, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_disjoint_interval_tracker_core;
   timeunit 1ns;
   timeprecision 1ps;

   import dit_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RESET_CYCLES    = 9;
   localparam int MAX_REPORTS     = 10;
   localparam int RANDOM_PHASES   = 3;
   localparam int ITEMS_PER_PHASE = 100;
   // An add may scan and shift the whole table before it answers.
   localparam int DRAIN_CYCLES    = 2 * MAX_RANGES + 8;
   localparam int DIRECTED_ROWS   = 26;

   // One response as the block presents it.
   typedef struct packed {
      logic       is_entry;
      status_type status;
      value_type  range_lo;
      value_type  range_hi;
      logic       valid;
      logic       last;
   } rsp_type;

   // One row of the directed table. Where typed is set, the expected status
   // of an add is the one written in the row rather than the predicted one.
   typedef struct packed {
      logic       func;
      value_type  value;
      logic       typed;
      status_type status;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_func;
   logic [VAL_BITS-1:0] req_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_is_entry;
   logic [2:0]          rsp_status;
   logic [VAL_BITS-1:0] rsp_range_start;
   logic [VAL_BITS-1:0] rsp_range_end;
   logic                rsp_entry_valid;
   logic                rsp_last;

   // Predictor state: the sorted range table and its occupancy.
   value_type tbl_lo [MAX_RANGES];
   value_type tbl_hi [MAX_RANGES];
   count_type tbl_count;

   rsp_type     expected_rsp [$];
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left  = 0;
   logic        idle_on;
   logic        cur_typed;
   status_type  cur_status;

   // The directed part: an empty list straight after reset, both ends of the
   // value range, a repeated value, growth on either side, a bridging merge,
   // then the table filled to capacity so that a new range is dropped while
   // a merge still goes through.
   dir_row_type directed_rows [DIRECTED_ROWS] = '{
      {FUNC_LIST, 16'd0,     1'b1, ST_NEW},
      {FUNC_ADD,  16'd65535, 1'b1, ST_NEW},
      {FUNC_ADD,  16'd0,     1'b1, ST_NEW},
      {FUNC_ADD,  16'd0,     1'b1, ST_PRESENT},
      {FUNC_ADD,  16'd65534, 1'b1, ST_EXTENDED},
      {FUNC_ADD,  16'd1,     1'b1, ST_EXTENDED},
      {FUNC_ADD,  16'd3,     1'b1, ST_NEW},
      {FUNC_ADD,  16'd2,     1'b1, ST_MERGED},
      {FUNC_LIST, 16'hFFFF,  1'b0, ST_NEW},
      {FUNC_ADD,  16'd10,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd12,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd14,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd16,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd18,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd20,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd22,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd24,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd26,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd28,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd30,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd32,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd34,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd36,    1'b1, ST_NEW},
      {FUNC_ADD,  16'd501,   1'b1, ST_FULL},
      {FUNC_ADD,  16'd11,    1'b1, ST_MERGED},
      {FUNC_LIST, 16'h5A5A,  1'b0, ST_NEW}
   };

   disjoint_interval_tracker_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_entry    (rsp_is_entry),
      .rsp_status      (rsp_status),
      .rsp_range_start (rsp_range_start),
      .rsp_range_end   (rsp_range_end),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_last        (rsp_last)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Inserts one value into the predicted table and returns the outcome.
   // Nothing wraps: value 0 has no left neighbour and the top value no
   // right neighbour.
   function automatic status_type insert_value(input value_type v);
      int   pos;
      int   n;
      logic joins_left;
      logic joins_right;
      n           = int'(tbl_count);
      pos         = 0;
      joins_left  = 1'b0;
      joins_right = 1'b0;
      // Find the first range whose upper end is not below the value.
      while (pos < n && tbl_hi[pos] < v)
         pos++;
      if (pos < n && tbl_lo[pos] <= v)
         return ST_PRESENT;
      if (pos > 0 && v != '0)
         joins_left = (tbl_hi[pos-1] == v - value_type'(1));
      if (pos < n && v != VAL_TOP)
         joins_right = (tbl_lo[pos] == v + value_type'(1));
      if (joins_left && joins_right) begin
         // The value bridges two ranges: fold the upper into the lower and
         // close the gap it leaves.
         tbl_hi[pos-1] = tbl_hi[pos];
         for (int i = pos; i < n - 1; i++) begin
            tbl_lo[i] = tbl_lo[i+1];
            tbl_hi[i] = tbl_hi[i+1];
         end
         tbl_count = tbl_count - count_type'(1);
         return ST_MERGED;
      end
      if (joins_left) begin
         tbl_hi[pos-1] = v;
         return ST_EXTENDED;
      end
      if (joins_right) begin
         tbl_lo[pos] = v;
         return ST_EXTENDED;
      end
      if (n >= MAX_RANGES)
         return ST_FULL;
      for (int i = n; i > pos; i--) begin
         tbl_lo[i] = tbl_lo[i-1];
         tbl_hi[i] = tbl_hi[i-1];
      end
      tbl_lo[pos] = v;
      tbl_hi[pos] = v;
      tbl_count   = tbl_count + count_type'(1);
      return ST_NEW;
   endfunction

   // Works out the responses of one accepted request and queues them.
   task automatic predict_responses(input logic func, input value_type v);
      rsp_type    r;
      status_type st;
      r = '0;
      if (func == FUNC_ADD) begin
         st         = insert_value(v);
         r.status   = cur_typed ? cur_status : st;
         r.last     = 1'b1;
         expected_rsp.push_back(r);
      end else if (tbl_count == '0) begin
         r.is_entry = 1'b1;
         r.last     = 1'b1;
         expected_rsp.push_back(r);
      end else begin
         for (int i = 0; i < int'(tbl_count); i++) begin
            r.is_entry = 1'b1;
            r.status   = ST_NEW;
            r.range_lo = tbl_lo[i];
            r.range_hi = tbl_hi[i];
            r.valid    = 1'b1;
            r.last     = (i == int'(tbl_count) - 1);
            expected_rsp.push_back(r);
         end
      end
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s: expected entry=%0d status=%0d range=%h..%h valid=%0d last=%0d,",
                  $realtime, what, want.is_entry, want.status, want.range_lo, want.range_hi,
                  want.valid, want.last,
                  " got entry=%0d status=%0d range=%h..%h valid=%0d last=%0d",
                  got.is_entry, got.status, got.range_lo, got.range_hi, got.valid, got.last);
   endtask

   // Both handshakes are observed here on the rising edge. A request is
   // predicted before any response is checked, although no response can
   // leave the block on the edge at which its request is taken.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      logic    bad;
      if (!reset) begin
         if (req_valid && req_ready)
            predict_responses(req_func, req_value);
         if (rsp_valid && rsp_ready) begin
            got.is_entry = rsp_is_entry;
            got.status   = status_type'(rsp_status);
            got.range_lo = rsp_range_start;
            got.range_hi = rsp_range_end;
            got.valid    = rsp_entry_valid;
            got.last     = rsp_last;
            if (expected_rsp.size() == 0) begin
               note_mismatch("response with no request outstanding", '0, got);
            end else begin
               want = expected_rsp.pop_front();
               bad  = (got.is_entry !== want.is_entry) || (got.status !== want.status) ||
                      (got.range_lo !== want.range_lo) || (got.range_hi !== want.range_hi) ||
                      (got.valid !== want.valid) || (got.last !== want.last);
               if (bad)
                  note_mismatch("response mismatch", want, got);
            end
         end
      end
   end

   // Response back-pressure: mostly ready, with short stalls and the odd long
   // one, and no new stall starts while idling is switched off.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Gap before the next request: mostly none or short, now and then long.
   function automatic int unsigned request_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Presents one request from a falling edge and holds it until taken,
   // returning on the falling edge after acceptance.
   task automatic send_request(input logic func, input value_type value, input logic typed,
                               input status_type status);
      int unsigned gap;
      gap = request_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_typed  = typed;
      cur_status = status;
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Lowers the request and lets every outstanding response come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic        func;
      value_type   value;
      value_type   window;
      int unsigned roll;
      int          idx;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_func  = FUNC_ADD;
      req_value = '0;
      rsp_ready = 1'b0;
      idle_on   = 1'b1;
      cur_typed = 1'b0;
      cur_status = ST_NEW;
      tbl_count = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].func, directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].status);
      drain_responses();

      // Random phases. Most adds land on or beside a range already held, so
      // that extensions, merges and repeats keep happening while the table
      // sits near capacity; the rest go to a small window, the two ends of
      // the value range or anywhere at all. The middle phase runs without
      // idling on either channel, and the sender waits for every response
      // between phases.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase != 1);
         window  = value_type'($urandom);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            roll  = $urandom_range(0, 99);
            func  = FUNC_ADD;
            value = value_type'($urandom);
            if (roll < 15) begin
               func = FUNC_LIST;
            end else if (roll < 60 && tbl_count != '0) begin
               idx = $urandom_range(0, int'(tbl_count) - 1);
               case ($urandom_range(0, 5))
                  0:       value = tbl_lo[idx] - 16'd2;
                  1:       value = tbl_lo[idx] - 16'd1;
                  2:       value = tbl_lo[idx];
                  3:       value = tbl_hi[idx];
                  4:       value = tbl_hi[idx] + 16'd1;
                  default: value = tbl_hi[idx] + 16'd2;
               endcase
            end else if (roll < 85) begin
               value = window + value_type'($urandom_range(0, 47));
            end else if (roll < 92) begin
               value = ($urandom_range(0, 1) != 0) ? value_type'($urandom_range(0, 3))
                                                   : VAL_TOP - value_type'($urandom_range(0, 3));
            end
            send_request(func, value, 1'b0, ST_NEW);
         end
         drain_responses();
      end

      // Allow for any stray response still working its way out.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
design/dit_pkg.sv
design/disjoint_interval_tracker_core.sv
tb/tb_disjoint_interval_tracker_core.sv
